/* sv/bpsc_pkg.sv */
// ----------------------------------------------------------------------------
// bpsc_pkg: shared types and constants
// Codes, table sizes and the command and result records that pass between
// the front, the back and the top level of the button press sequence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsc_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QP_W          = 1;
	localparam int QC_W          = 2;

	// input op codes
	localparam logic [2:0] OP_DOWN   = 3'd0;
	localparam logic [2:0] OP_UP     = 3'd1;
	localparam logic [2:0] OP_CANCEL = 3'd2;
	localparam logic [2:0] OP_MOVE   = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	// result kinds
	localparam logic [1:0] K_DOWN   = 2'd0;
	localparam logic [1:0] K_UP     = 2'd1;
	localparam logic [1:0] K_CANCEL = 2'd2;
	localparam logic [1:0] K_MOVE   = 2'd3;

	// configuration register indexes
	localparam logic CFG_FIX_ENABLE = 1'b0;
	localparam logic CFG_TIMEOUT    = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd30;

	typedef enum logic [2:0] {
		ST_NONE   = 3'd0,
		ST_DOWN   = 3'd1,
		ST_MOVE   = 3'd2,
		ST_UP     = 3'd3,
		ST_CANCEL = 3'd4
	} pst_t;

	typedef enum logic [2:0] {
		C_NOP    = 3'd0,
		C_DOWN   = 3'd1,
		C_UP     = 3'd2,
		C_CANCEL = 3'd3,
		C_MOVE   = 3'd4,
		C_TICK   = 3'd5
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t          code;
		logic               track;
		logic [7:0]         source;
		logic [3:0]         touch;
		logic [7:0]         button;
		logic [15:0]        window;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               faked;
		logic [7:0]         source;
		logic [3:0]         touch;
		logic [7:0]         button;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} result_t;

	typedef struct packed {
		logic        fix_enable;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic pend_v;
	} stat_t;

endpackage

`default_nettype wire

/* sv/bpsc_if.sv */
// ----------------------------------------------------------------------------
// bpsc_in_if / bpsc_out_if: event channels
// Valid/ready channels for input events and cleaned result events.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpsc_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic [7:0]         source_id;
	logic [3:0]         touch_id;
	logic [7:0]         button;
	logic [15:0]        window;
	logic               target_ok;
	logic signed [15:0] x;
	logic signed [15:0] y;

	modport source (output valid, op, source_id, touch_id, button, window, target_ok, x, y,
		input ready);
	modport sink (input valid, op, source_id, touch_id, button, window, target_ok, x, y,
		output ready);
endinterface

interface bpsc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic               faked;
	logic [7:0]         out_source;
	logic [3:0]         out_touch;
	logic [7:0]         out_button;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic               last;

	modport source (output valid, kind, faked, out_source, out_touch, out_button, out_x,
		out_y, last, input ready);
	modport sink (input valid, kind, faked, out_source, out_touch, out_button, out_x,
		out_y, last, output ready);
endinterface

`default_nettype wire

/* sv/bpsc_front.sv */
// ----------------------------------------------------------------------------
// bpsc_front: event classifier and command queue
// Decodes each input beat into a command, drops beats that do nothing and
// holds up to two commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bpsc_in_if.sink            in_ch,
	input  wire logic          fix_enable,
	output bpsc_pkg::cmd_t     cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_ready
);
	import bpsc_pkg::*;

	cmd_t            cls;
	cmd_t            mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wp_q;
	logic [QP_W-1:0] rp_q;
	logic [QC_W-1:0] cnt_q;
	logic            push;
	logic            pop;

	always_comb begin
		cls.code = C_NOP;
		case (in_ch.op)
			OP_DOWN:   cls.code = in_ch.target_ok ? C_DOWN : C_NOP;
			OP_UP:     cls.code = in_ch.target_ok ? C_UP : C_NOP;
			OP_CANCEL: cls.code = in_ch.target_ok ? C_CANCEL : C_NOP;
			OP_MOVE:   cls.code = in_ch.target_ok ? C_MOVE : C_NOP;
			OP_TICK:   cls.code = C_TICK;
			default:   cls.code = C_NOP;
		endcase
		cls.track  = (in_ch.touch_id == 4'd0) && fix_enable;
		cls.source = in_ch.source_id;
		cls.touch  = in_ch.touch_id;
		cls.button = in_ch.button;
		cls.window = in_ch.window;
		cls.x      = in_ch.x;
		cls.y      = in_ch.y;
	end

	assign in_ch.ready = (cnt_q != QC_W'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready && (cls.code != C_NOP);
	assign cmd_valid   = (cnt_q != '0);
	assign pop         = cmd_valid && cmd_ready;
	assign cmd         = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QC_W'(push) - QC_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* sv/bpsc_back.sv */
// ----------------------------------------------------------------------------
// bpsc_back: press table and command sequencer
// Walks the press table one entry per cycle unless a tick's result is held,
// updates it and emits results via a pending stage into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  bpsc_pkg::cfg_t     cfg,
	input  bpsc_pkg::cmd_t     cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	bpsc_out_if.source         out_ch,
	output bpsc_pkg::stat_t    stat
);
	import bpsc_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCAN   = 9'b000000010,
		S_DOWN   = 9'b000000100,
		S_DOWN2  = 9'b000001000,
		S_UP     = 9'b000010000,
		S_CANCEL = 9'b000100000,
		S_MOVE   = 9'b001000000,
		S_TICK   = 9'b010000000,
		S_FLUSH  = 9'b100000000
	} fsm_t;

	fsm_t             state_q, state_d;
	cmd_t             cur_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             hit_q, free_q, newent_q;
	logic [IDX_W-1:0] hidx_q, fidx_q;
	logic [CNT_W-1:0] cnt_q;

	// press table
	logic        used_q [TABLE_ENTRIES];
	pst_t        pst_q  [TABLE_ENTRIES];
	logic        sv_q   [TABLE_ENTRIES];
	logic [15:0] cd_q   [TABLE_ENTRIES];
	logic [7:0]  src_q  [TABLE_ENTRIES];
	logic [3:0]  tch_q  [TABLE_ENTRIES];
	logic [7:0]  btn_q  [TABLE_ENTRIES];
	logic [15:0] win_q  [TABLE_ENTRIES];
	logic [15:0] sx_q   [TABLE_ENTRIES];
	logic [15:0] sy_q   [TABLE_ENTRIES];

	// entry at idx_q, and its next value
	logic        e_used, e_sv;
	pst_t        e_pst;
	logic [15:0] e_cd, e_win;
	logic        wr;
	logic        n_used, n_sv;
	pst_t        n_pst;
	logic [15:0] n_cd, n_win, n_sx, n_sy;
	logic [7:0]  n_src, n_btn;
	logic [3:0]  n_tch;

	// result path
	result_t     pend_q, out_q, em_data;
	logic        pend_v_q, out_v_q, out_last_q;
	logic        em, fl, em_ok, can_push, push_out;

	logic        armed, last_idx, match, hit_now, free_now, active;
	logic [IDX_W-1:0] hidx_now, fidx_now;
	logic        win_eq, need_fake, fire;
	logic        sel_new, sel_hit, sel_done, hit_set, free_set;

	assign armed    = cfg.fix_enable && (cfg.timeout_ticks != '0);
	assign e_used   = used_q[idx_q];
	assign e_pst    = pst_q[idx_q];
	assign e_sv     = sv_q[idx_q];
	assign e_cd     = cd_q[idx_q];
	assign e_win    = win_q[idx_q];
	assign last_idx = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign active   = (e_pst == ST_DOWN) || (e_pst == ST_MOVE);
	assign match    = e_used && (src_q[idx_q] == cur_q.source) &&
		(tch_q[idx_q] == cur_q.touch) && (btn_q[idx_q] == cur_q.button);
	assign hit_now  = hit_q || match;
	assign hidx_now = hit_q ? hidx_q : idx_q;
	assign free_now = free_q || !e_used;
	assign fidx_now = free_q ? fidx_q : idx_q;
	assign win_eq    = newent_q || (e_win == cur_q.window);
	assign need_fake = !newent_q && win_eq && active;
	assign fire      = e_used && active;

	assign can_push = !out_v_q || out_ch.ready;
	assign em_ok    = !pend_v_q || can_push;
	assign push_out = (em && pend_v_q) || fl;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cmd_ready = 1'b0;
		em        = 1'b0;
		fl        = 1'b0;
		em_data   = '{kind: K_UP, faked: 1'b0, source: cur_q.source, touch: cur_q.touch,
			button: cur_q.button, x: cur_q.x, y: cur_q.y};
		wr        = 1'b0;
		n_used    = e_used;
		n_pst     = e_pst;
		n_sv      = e_sv;
		n_cd      = e_cd;
		n_win     = e_win;
		n_src     = src_q[idx_q];
		n_tch     = tch_q[idx_q];
		n_btn     = btn_q[idx_q];
		n_sx      = sx_q[idx_q];
		n_sy      = sy_q[idx_q];
		sel_new   = 1'b0;
		sel_hit   = 1'b0;
		sel_done  = 1'b0;
		hit_set   = 1'b0;
		free_set  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_ready = 1'b1;
					idx_d     = '0;
					em_data   = '{kind: K_CANCEL, faked: 1'b0, source: cmd.source,
						touch: cmd.touch, button: cmd.button, x: cmd.x, y: cmd.y};
					case (cmd.code)
						C_DOWN, C_UP: state_d = S_SCAN;
						C_CANCEL: begin
							em      = 1'b1;
							state_d = S_CANCEL;
						end
						C_MOVE: begin
							em             = 1'b1;
							em_data.kind   = K_MOVE;
							em_data.button = 8'd0;
							state_d        = cmd.track ? S_MOVE : S_FLUSH;
						end
						C_TICK:  state_d = S_TICK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				hit_set  = match && !hit_q;
				free_set = !e_used && !free_q;
				if (last_idx) begin
					if (hit_now) begin
						idx_d   = hidx_now;
						sel_hit = 1'b1;
						state_d = (cur_q.code == C_DOWN) ? S_DOWN : S_UP;
					end else if (free_now && (cur_q.code == C_DOWN)) begin
						idx_d   = fidx_now;
						sel_new = 1'b1;
						state_d = S_DOWN;
					end else begin
						state_d = S_FLUSH;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_DOWN: begin
				if (!need_fake || em_ok) begin
					em            = need_fake;
					em_data.faked = 1'b1;
					wr            = 1'b1;
					n_used        = 1'b1;
					if (newent_q) begin
						n_src = cur_q.source;
						n_tch = cur_q.touch;
						n_btn = cur_q.button;
						n_sv  = 1'b0;
						n_cd  = '0;
					end
					n_pst = ST_DOWN;
					n_win = cur_q.window;
					if (armed) begin
						n_sx = cur_q.x;
						n_sy = cur_q.y;
						n_sv = 1'b1;
						n_cd = cfg.timeout_ticks;
					end
					state_d = S_DOWN2;
				end
			end
			S_DOWN2: begin
				if (em_ok) begin
					em           = 1'b1;
					em_data.kind = K_DOWN;
					state_d      = S_FLUSH;
				end
			end
			S_UP: begin
				if ((e_win == cur_q.window) && ((e_pst == ST_UP) || (e_pst == ST_CANCEL))) begin
					state_d = S_FLUSH;
				end else if (em_ok) begin
					em    = 1'b1;
					wr    = 1'b1;
					n_pst = ST_UP;
					n_win = cur_q.window;
					if (armed) begin
						n_cd = '0;
						n_sv = 1'b0;
					end
					state_d = S_FLUSH;
				end
			end
			S_CANCEL: begin
				if (e_used && (e_pst != ST_UP)) begin
					wr    = 1'b1;
					n_pst = ST_CANCEL;
				end
				sel_done = 1'b1;
			end
			S_MOVE: begin
				if (e_used && e_sv && active) begin
					wr    = 1'b1;
					n_cd  = (cfg.timeout_ticks != '0) ? cfg.timeout_ticks : e_cd;
					n_sx  = cur_q.x;
					n_sy  = cur_q.y;
					n_pst = ST_MOVE;
				end
				sel_done = 1'b1;
			end
			S_TICK: begin
				if (e_cd == '0) begin
					sel_done = 1'b1;
				end else if (e_cd != 16'd1) begin
					wr       = 1'b1;
					n_cd     = e_cd - 16'd1;
					sel_done = 1'b1;
				end else if (fire && (cnt_q >= CNT_W'(MAX_RESULTS))) begin
					sel_done = 1'b1;
				end else if (!fire || em_ok) begin
					wr       = 1'b1;
					n_cd     = '0;
					n_sv     = 1'b0;
					em       = fire;
					em_data  = '{kind: K_UP, faked: 1'b1, source: src_q[idx_q],
						touch: tch_q[idx_q], button: btn_q[idx_q],
						x: e_sv ? sx_q[idx_q] : 16'd0, y: e_sv ? sy_q[idx_q] : 16'd0};
					sel_done = 1'b1;
				end
			end
			S_FLUSH: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (can_push) begin
					fl      = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// advance a table walk, or leave it after the last entry
		if (sel_done) begin
			if (last_idx) begin
				state_d = S_FLUSH;
			end else begin
				idx_d = idx_q + 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			newent_q   <= 1'b0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				used_q[i] <= 1'b0;
				pst_q[i]  <= ST_NONE;
				sv_q[i]   <= 1'b0;
				cd_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd_ready && cmd_valid) begin
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
				newent_q <= 1'b0;
				cnt_q    <= '0;
			end
			if (hit_set) begin
				hit_q <= 1'b1;
			end
			if (free_set) begin
				free_q <= 1'b1;
			end
			if (sel_new) begin
				newent_q <= 1'b1;
			end else if (sel_hit) begin
				newent_q <= 1'b0;
			end
			if (em && (state_q == S_TICK)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (wr) begin
				used_q[idx_q] <= n_used;
				pst_q[idx_q]  <= n_pst;
				sv_q[idx_q]   <= n_sv;
				cd_q[idx_q]   <= n_cd;
			end
			if (em) begin
				pend_v_q <= 1'b1;
			end else if (fl) begin
				pend_v_q <= 1'b0;
			end
			if (push_out) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (hit_set) begin
			hidx_q <= idx_q;
		end
		if (free_set) begin
			fidx_q <= idx_q;
		end
		if (cmd_ready && cmd_valid) begin
			cur_q <= cmd;
		end
		if (wr) begin
			src_q[idx_q] <= n_src;
			tch_q[idx_q] <= n_tch;
			btn_q[idx_q] <= n_btn;
			win_q[idx_q] <= n_win;
			sx_q[idx_q]  <= n_sx;
			sy_q[idx_q]  <= n_sy;
		end
		if (em) begin
			pend_q <= em_data;
		end
		if (push_out) begin
			out_q      <= pend_q;
			out_last_q <= fl;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.kind       = out_q.kind;
	assign out_ch.faked      = out_q.faked;
	assign out_ch.out_source = out_q.source;
	assign out_ch.out_touch  = out_q.touch;
	assign out_ch.out_button = out_q.button;
	assign out_ch.out_x      = out_q.x;
	assign out_ch.out_y      = out_q.y;
	assign out_ch.last       = out_last_q;

	assign stat.idle   = (state_q == S_IDLE);
	assign stat.pend_v = pend_v_q;

endmodule

`default_nettype wire

/* sv/button_press_sequence_checker.sv */
// ----------------------------------------------------------------------------
// button_press_sequence_checker: pointer and touch button event cleaner
// Tracks press state per (source, touch point, button) and emits a
// consistent event stream with faked ups where presses got stuck.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event per beat (down, up, cancel, move, tick). out_ch
//   carries zero to eight result beats per event; the final one has last set.
//   Events that make no result (target not ok, unknown op) are consumed in the
//   front end and never reach the table.
//   The front end decodes events into a two-deep command queue, so input beats
//   are taken while the back end works and while a result waits on out_ch.
//   The back end walks the eight table entries one per cycle; a tick's walk
//   waits while a result cannot move on. A down runs take, eight-entry scan,
//   update, second result, drain; an up take, scan, update, drain; a cancel,
//   tracked move or tick take, walk, drain; an untracked move take, drain.
//   A result sits in a pending stage until the next one or the end of the
//   event decides its last flag; a stalled out_ch simply holds the back end.
//   Reset clears the table, stops all timers, sets fix_enable to 0 and
//   timeout_ticks to 30. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_sequence_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bpsc_in_if.sink          in_ch,
	bpsc_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import bpsc_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	logic  cmd_valid;
	logic  cmd_ready;
	stat_t stat;

	// configuration registers: decode index, hold until the next write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fix_enable    <= 1'b0;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIX_ENABLE: cfg_q.fix_enable    <= cfg_wdata[0];
				CFG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_wdata;
				default:        cfg_q.fix_enable    <= cfg_q.fix_enable;
			endcase
		end
	end

	// front end: classify each beat and queue the commands that act
	bpsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.fix_enable (cfg_q.fix_enable),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready)
	);

	// back end: table walk, updates and result beats
	bpsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.out_ch    (out_ch),
		.stat      (stat)
	);

	// an idle back end never holds an undelivered result
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		stat.idle |-> !stat.pend_v)
		else $error("pending result left behind at idle");

	// a new output beat only appears while a command is being worked on
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(!stat.idle))
		else $error("output beat produced while idle");

	// the back end takes a command only when idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |-> stat.idle)
		else $error("command taken while busy");

endmodule

`default_nettype wire

/* sim/bpsc_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_monitor: predicts and checks the cleaned event stream
// Watches the event and result channels and the register writes, keeps its
// own copy of the press table, and compares every result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsc_monitor
	import bpsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	bpsc_in_if.sink          in_ch,
	bpsc_out_if.sink         out_ch,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic        faked;
		logic [7:0]  src;
		logic [3:0]  tch;
		logic [7:0]  btn;
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
	} beat_t;

	beat_t       awaited[$];
	logic        fix_en;
	logic [15:0] tmo;
	logic        used[TABLE_ENTRIES];
	logic [7:0]  e_src[TABLE_ENTRIES];
	logic [3:0]  e_tch[TABLE_ENTRIES];
	logic [7:0]  e_btn[TABLE_ENTRIES];
	logic [15:0] e_win[TABLE_ENTRIES];
	pst_t        pst[TABLE_ENTRIES];
	logic        sv_ok[TABLE_ENTRIES];
	logic [15:0] sv_x[TABLE_ENTRIES];
	logic [15:0] sv_y[TABLE_ENTRIES];
	logic [15:0] cnt[TABLE_ENTRIES];

	assign pending = awaited.size();

	function automatic beat_t mk(logic [1:0] k, logic f, logic [7:0] s, logic [3:0] t,
		logic [7:0] b, logic [15:0] px, logic [15:0] py);
		beat_t r;
		r = '{kind: k, faked: f, src: s, tch: t, btn: b, x: px, y: py, last: 1'b0};
		return r;
	endfunction

	// Run one event through the press table and queue the beats it causes.
	task automatic clean_event(logic [2:0] op, logic [7:0] s, logic [3:0] t, logic [7:0] b,
		logic [15:0] w, logic ok, logic [15:0] px, logic [15:0] py);
		beat_t out[$];
		int e;
		logic armed;
		logic fire;
		armed = fix_en && tmo != 0;
		e = -1;
		if (op inside {OP_DOWN, OP_UP}) begin
			for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
				if (used[i] && e_src[i] == s && e_tch[i] == t && e_btn[i] == b) e = i;
		end
		if (op == OP_DOWN && ok) begin
			if (e < 0) begin
				for (int i = TABLE_ENTRIES - 1; i >= 0; i--) if (!used[i]) e = i;
				if (e >= 0) begin
					used[e] = 1; e_src[e] = s; e_tch[e] = t; e_btn[e] = b; e_win[e] = w;
					pst[e] = ST_NONE; sv_ok[e] = 0; cnt[e] = 0;
				end
			end
			if (e >= 0) begin
				if (e_win[e] == w && pst[e] inside {ST_DOWN, ST_MOVE})
					out.push_back(mk(K_UP, 1, s, t, b, px, py));
				pst[e] = ST_DOWN;
				e_win[e] = w;
				if (armed) begin
					sv_x[e] = px; sv_y[e] = py; sv_ok[e] = 1; cnt[e] = tmo;
				end
				out.push_back(mk(K_DOWN, 0, s, t, b, px, py));
			end
		end else if (op == OP_UP && ok) begin
			if (e >= 0 && !(e_win[e] == w && pst[e] inside {ST_UP, ST_CANCEL})) begin
				pst[e] = ST_UP;
				e_win[e] = w;
				if (armed) begin
					cnt[e] = 0; sv_ok[e] = 0;
				end
				out.push_back(mk(K_UP, 0, s, t, b, px, py));
			end
		end else if (op == OP_CANCEL && ok) begin
			out.push_back(mk(K_CANCEL, 0, s, t, b, px, py));
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (used[i] && pst[i] != ST_UP) pst[i] = ST_CANCEL;
		end else if (op == OP_MOVE && ok) begin
			if (t == 0 && fix_en) begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (used[i] && sv_ok[i] && pst[i] inside {ST_DOWN, ST_MOVE}) begin
						if (tmo != 0) cnt[i] = tmo;
						sv_x[i] = px; sv_y[i] = py; pst[i] = ST_MOVE;
					end
			end
			out.push_back(mk(K_MOVE, 0, s, t, 8'd0, px, py));
		end else if (op == OP_TICK) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (cnt[i] > 1) cnt[i] = cnt[i] - 1;
				else if (cnt[i] == 1) begin
					fire = used[i] && pst[i] inside {ST_DOWN, ST_MOVE};
					if (!(fire && out.size() >= MAX_RESULTS)) begin
						cnt[i] = 0;
						if (fire)
							out.push_back(mk(K_UP, 1, e_src[i], e_tch[i], e_btn[i],
								sv_ok[i] ? sv_x[i] : 16'd0, sv_ok[i] ? sv_y[i] : 16'd0));
						sv_ok[i] = 0;
					end
				end
			end
		end
		if (out.size() > 0) out[out.size() - 1].last = 1'b1;
		foreach (out[k]) awaited.push_back(out[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t got;
		beat_t exp_b;
		if (!arst_n) begin
			errors <= 0;
			awaited.delete();
			fix_en = 0;
			tmo = TIMEOUT_RESET;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				used[i] = 0; pst[i] = ST_NONE; sv_ok[i] = 0; cnt[i] = 0;
				e_src[i] = 0; e_tch[i] = 0; e_btn[i] = 0; e_win[i] = 0;
				sv_x[i] = 0; sv_y[i] = 0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FIX_ENABLE) fix_en = cfg_wdata[0];
				else tmo = cfg_wdata;
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{kind: out_ch.kind, faked: out_ch.faked, src: out_ch.out_source,
					tch: out_ch.out_touch, btn: out_ch.out_button, x: out_ch.out_x,
					y: out_ch.out_y, last: out_ch.last};
				if (awaited.size() == 0) begin
					$error("unexpected result beat kind=%0d", got.kind);
					errors <= errors + 1;
				end else begin
					exp_b = awaited.pop_front();
					if (got != exp_b) begin
						if (got.kind != exp_b.kind)
							$error("kind: expected %0d, got %0d", exp_b.kind, got.kind);
						if (got.faked != exp_b.faked)
							$error("faked: expected %0d, got %0d", exp_b.faked, got.faked);
						if (got.src != exp_b.src)
							$error("out_source: expected %0d, got %0d", exp_b.src, got.src);
						if (got.tch != exp_b.tch)
							$error("out_touch: expected %0d, got %0d", exp_b.tch, got.tch);
						if (got.btn != exp_b.btn)
							$error("out_button: expected %0d, got %0d", exp_b.btn, got.btn);
						if (got.x != exp_b.x)
							$error("out_x: expected %0d, got %0d",
								$signed(exp_b.x), $signed(got.x));
						if (got.y != exp_b.y)
							$error("out_y: expected %0d, got %0d",
								$signed(exp_b.y), $signed(got.y));
						if (got.last != exp_b.last)
							$error("last: expected %0d, got %0d", exp_b.last, got.last);
						errors <= errors + 1;
					end
				end
			end
			// The event is predicted after the result check: its beats can only
			// show up on a later edge.
			if (in_ch.valid && in_ch.ready)
				clean_event(in_ch.op, in_ch.source_id, in_ch.touch_id, in_ch.button,
					in_ch.window, in_ch.target_ok, in_ch.x, in_ch.y);
		end
	end

endmodule

`default_nettype wire

/* sim/button_press_sequence_checker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_sequence_checker_test: stimulus for the press sequence checker
// Drives directed and random button event sequences with random gaps on both
// channels, walks the register settings between phases, and reports the
// verdict from the monitor's error count.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_sequence_checker_test;
	import bpsc_pkg::*;

	localparam int CYCLE_LIMIT = 900000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;
	int          errors;
	int          pending;
	int          cycles = 0;

	bpsc_in_if  in_ch ();
	bpsc_out_if out_ch ();

	button_press_sequence_checker dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	bpsc_monitor monitor (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Give up on a hang; the limit is far above the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Gap length: mostly short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Stall the result channel at random, with stretches of steady ready.
	initial begin
		int hold;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = gap_len();
			if ($urandom_range(0, 9) == 0) hold = 0;
			out_ch.ready <= (hold == 0);
			repeat (hold == 0 ? $urandom_range(1, 30) : hold) @(posedge clk);
		end
	end

	// Offer one event beat and hold it until it is taken; ready is sampled
	// mid-cycle so it is the value seen at the next rising edge.
	task automatic send_event(logic [2:0] op, logic [7:0] s, logic [3:0] t, logic [7:0] b,
		logic [15:0] w, logic ok, logic [15:0] px, logic [15:0] py);
		logic taken;
		in_ch.valid     <= 1'b1;
		in_ch.op        <= op;
		in_ch.source_id <= s;
		in_ch.touch_id  <= t;
		in_ch.button    <= b;
		in_ch.window    <= w;
		in_ch.target_ok <= ok;
		in_ch.x         <= px;
		in_ch.y         <= py;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Drop valid and wait a random gap, unless the next beat follows directly.
	task automatic idle_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drain all results, then let dropped events clear the front end.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random event: mostly press sequences on a small key set so keys repeat.
	task automatic random_event(int mode);
		logic [2:0]  op;
		logic [7:0]  s;
		logic [3:0]  t;
		logic [7:0]  b;
		logic [15:0] w;
		logic        ok;
		int p;
		p = $urandom_range(0, 99);
		if (p < 30) op = OP_DOWN;
		else if (p < 50) op = OP_UP;
		else if (p < 55) op = OP_CANCEL;
		else if (p < 70) op = OP_MOVE;
		else if (p < 97) op = OP_TICK;
		else op = 3'($urandom_range(5, 7));
		if (mode == 0) begin
			s = 8'($urandom_range(0, 2));
			t = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
			b = 8'($urandom_range(1, 3));
			w = 16'($urandom_range(0, 1));
		end else begin
			s = 8'($urandom);
			t = 4'($urandom);
			b = 8'($urandom);
			w = 16'($urandom);
		end
		ok = ($urandom_range(0, 9) != 0);
		send_event(op, s, t, b, w, ok, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_FIX_ENABLE;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.op        = OP_TICK;
		in_ch.source_id = '0;
		in_ch.touch_id  = '0;
		in_ch.button    = '0;
		in_ch.window    = '0;
		in_ch.target_ok = 1'b0;
		in_ch.x         = '0;
		in_ch.y         = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, fix-up off.
		send_event(OP_UP, 8'd1, 4'd0, 8'd1, 16'd5, 1, 16'd1, 16'd1);  // no history
		send_event(OP_DOWN, 8'd1, 4'd0, 8'd1, 16'd5, 1, 16'h7FFF, 16'h8000);
		send_event(OP_DOWN, 8'd1, 4'd0, 8'd1, 16'd5, 1, 16'h8000, 16'h7FFF);  // fake up
		send_event(OP_DOWN, 8'd1, 4'd0, 8'd1, 16'd6, 1, 16'd3, 16'd3);  // other window
		send_event(OP_DOWN, 8'd2, 4'd0, 8'd1, 16'd6, 0, 16'd3, 16'd3);  // target not ok
		send_event(OP_UP, 8'd1, 4'd0, 8'd1, 16'd6, 1, 16'd4, 16'd4);
		send_event(OP_UP, 8'd1, 4'd0, 8'd1, 16'd6, 1, 16'd4, 16'd4);  // repeated up
		send_event(OP_MOVE, 8'hFF, 4'hF, 8'hFF, 16'hFFFF, 1, 16'hFFFF, 16'd0);
		send_event(3'd7, 8'd0, 4'd0, 8'd0, 16'd0, 1, 16'd0, 16'd0);
		send_event(OP_CANCEL, 8'hFF, 4'hF, 8'hFF, 16'hFFFF, 1, 16'd9, 16'd9);
		drain();

		// Fix-up on with a short timeout; fill the table past its size.
		write_reg(CFG_FIX_ENABLE, 16'd1);
		write_reg(CFG_TIMEOUT, 16'd2);
		for (int i = 0; i < TABLE_ENTRIES + 2; i++)
			send_event(OP_DOWN, 8'(10 + i), 4'(i), 8'(i), 16'd1, 1, 16'(i), 16'(-i));
		send_event(OP_MOVE, 8'd0, 4'd0, 8'd0, 16'd0, 1, 16'h1234, 16'h4321);
		send_event(OP_CANCEL, 8'd0, 4'd0, 8'd0, 16'd0, 1, 16'd0, 16'd0);
		send_event(OP_UP, 8'd10, 4'd0, 8'd0, 16'd1, 1, 16'd0, 16'd0);  // up after cancel
		repeat (3) send_event(OP_TICK, 8'd0, 4'd0, 8'd0, 16'd0, 0, 16'd0, 16'd0);
		drain();

		// Random phases across settings, extremes included. The table fills and
		// stays full after reset, so fresh keys are only tried in the wide phase.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_TIMEOUT, 16'd1);
				end
				1: begin
					write_reg(CFG_TIMEOUT, 16'd0);
				end
				2: begin
					write_reg(CFG_FIX_ENABLE, 16'd0);
					write_reg(CFG_TIMEOUT, 16'd3);
				end
				3: begin
					write_reg(CFG_FIX_ENABLE, 16'd1);
					write_reg(CFG_TIMEOUT, 16'd4);
				end
				default: begin
					write_reg(CFG_TIMEOUT, 16'hFFFF);
				end
			endcase
			for (int n = 0; n < 64; n++) begin
				random_event((ph == 4 && n < 10) ? 1 : 0);
				idle_gap();
				// Hold off once until every result is back.
				if (ph == 1 && n == 30) drain();
			end
			drain();
		end

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
